@@ sv/wcs_pkg.sv @@
package wcs_pkg;

  localparam int Channels   = 16;
  localparam int ChBits     = 4;
  localparam int SmpBits    = 16;
  localparam int SqBits     = 48;
  localparam int SumBits    = 40;
  localparam int CntBits    = 16;
  localparam int DecBits    = 8;
  localparam int StateBits  = SqBits + SumBits + 2 * SmpBits + CntBits;

  localparam logic [0:0] RegWindowLen  = 1'b0;
  localparam logic [0:0] RegDecimation = 1'b1;

  // Per-channel accumulator record
  typedef struct packed {
    logic [SqBits-1:0]         sq;
    logic signed [SumBits-1:0] sum;
    logic signed [SmpBits-1:0] vmax;
    logic signed [SmpBits-1:0] vmin;
    logic [CntBits-1:0]        cnt;
  } acc_t;

  // Window-close job handed to the divide/root unit
  typedef struct packed {
    logic [ChBits-1:0]         ch;
    logic [SqBits-1:0]         sq;
    logic signed [SumBits-1:0] sum;
    logic signed [SmpBits-1:0] vmax;
    logic signed [SmpBits-1:0] vmin;
    logic [CntBits-1:0]        len;
  } job_t;

endpackage

@@ sv/wcs_acc_mem.sv @@
// Accumulator memory: one write port, one registered read port.
module wcs_acc_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [wcs_pkg::ChBits-1:0] waddr,
  input  wcs_pkg::acc_t             wdata,
  input  logic [wcs_pkg::ChBits-1:0] raddr,
  output wcs_pkg::acc_t             rdata
);
  import wcs_pkg::*;

  acc_t mem [Channels];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/wcs_math.sv @@
// Window-close math: restoring divides of sum of squares and |sum| by len,
// then a bit-pair integer square root. One quotient bit or root bit a cycle.
module wcs_math (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  wcs_pkg::job_t     job,
  output logic              busy,
  output logic              done,
  output logic [wcs_pkg::ChBits-1:0] r_ch,
  output logic [15:0]       r_rms,
  output logic [15:0]       r_mean,
  output logic [15:0]       r_max,
  output logic [15:0]       r_min,
  output logic [15:0]       r_p2p
);
  import wcs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROOT} st_t;
  st_t st;
  logic [5:0]          step;
  logic [SqBits-1:0]   qa;
  logic [CntBits:0]    rema;
  logic [SumBits-1:0]  qb;
  logic [CntBits:0]    remb;
  logic                neg;
  logic [CntBits-1:0]  len;
  logic [SqBits-1:0]   x;
  logic [SqBits-1:0]   res;
  logic [SqBits-1:0]   bitv;
  logic [CntBits:0]    ta, tb;
  logic [SqBits-1:0]   trial;
  logic [SumBits-1:0]  mq;

  assign ta    = {rema[CntBits-1:0], qa[SqBits-1]};
  assign tb    = {remb[CntBits-1:0], qb[SumBits-1]};
  assign trial = res + bitv;
  assign mq    = neg ? -qb : qb;
  assign busy  = (st != S_IDLE) || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: if (start) begin
          st    <= S_DIV;
          step  <= '0;
          qa    <= job.sq;
          rema  <= '0;
          neg   <= job.sum[SumBits-1];
          qb    <= job.sum[SumBits-1] ? -job.sum : job.sum;
          remb  <= '0;
          len   <= job.len;
          r_ch  <= job.ch;
          r_max <= job.vmax;
          r_min <= job.vmin;
          r_p2p <= 16'(job.vmax - job.vmin);
        end
        S_DIV: begin
          // one quotient bit per cycle for both dividends
          if (ta >= {1'b0, len}) begin
            rema <= ta - {1'b0, len};
            qa   <= {qa[SqBits-2:0], 1'b1};
          end else begin
            rema <= ta;
            qa   <= {qa[SqBits-2:0], 1'b0};
          end
          if (step < 6'(SumBits)) begin
            if (tb >= {1'b0, len}) begin
              remb <= tb - {1'b0, len};
              qb   <= {qb[SumBits-2:0], 1'b1};
            end else begin
              remb <= tb;
              qb   <= {qb[SumBits-2:0], 1'b0};
            end
          end
          step <= step + 6'd1;
          if (step == 6'(SqBits - 1)) begin
            st   <= S_ROOT;
            step <= '0;
          end
        end
        S_ROOT: begin
          if (step == 6'd0) begin
            x      <= qa;
            res    <= '0;
            bitv   <= {2'b01, {(SqBits-2){1'b0}}};
            r_mean <= mq[15:0];
          end else if (bitv == '0) begin
            r_rms <= res[15:0];
            st    <= S_IDLE;
            done  <= 1'b1;
          end else begin
            if (x >= trial) begin
              x   <= x - trial;
              res <= (res >> 1) + bitv;
            end else begin
              res <= res >> 1;
            end
            bitv <= bitv >> 2;
          end
          step <= step + 6'd1;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/windowed_channel_statistics_unit.sv @@
// A sample that closes a window has its result on the outputs after the memory read,
// the modify, the divide, the root and the handoff; others give none.
// A skipped-frame sample needs no memory access, a used one a read, modify and
// write of channel memory, a close also the divide and root; one sample at a time.
// A close also waits while the previous result still sits in the output register.
// Reset: registers back to 1000/4, frame phase 0, then a clearing pass over every
// channel memory entry during which no sample is taken.
module windowed_channel_statistics_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid,
  output logic                             ready,
  input  logic signed [15:0]               sample,
  input  logic [3:0]                       channel,
  input  logic                             frame_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       out_channel,
  output logic [15:0]                      rms,
  output logic signed [15:0]               mean,
  output logic signed [15:0]               maximum,
  output logic signed [15:0]               minimum,
  output logic [15:0]                      peak_to_peak,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [15:0]                      cfg_data
);
  import wcs_pkg::*;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_MOD, S_WAIT} st_t;
  st_t st;

  logic [CntBits-1:0] window_len;
  logic [DecBits-1:0] decimation;
  logic [DecBits-1:0] frame_phase;
  logic [ChBits-1:0]  clr_idx;

  logic signed [SmpBits-1:0] s_q;
  logic [ChBits-1:0]         ch_q;

  logic          we;
  logic [ChBits-1:0] waddr;
  acc_t          wdata, rdata, acc_new, acc_clr;
  job_t          job;
  logic          m_start, m_busy, m_done;
  logic [ChBits-1:0] m_ch;
  logic [15:0]   m_rms, m_mean, m_max, m_min, m_p2p;

  logic [DecBits-1:0] dec_eff;
  logic [CntBits-1:0] len_eff;
  logic               used;
  logic [SmpBits-1:0] mag;
  logic [SqBits-1:0]  sq;
  logic [SqBits:0]    sq_sum;
  logic signed [SumBits:0] ps;
  logic               close;
  logic               mod_go;

  assign dec_eff = (decimation == '0) ? DecBits'(1) : decimation;
  assign len_eff = (window_len == '0) ? CntBits'(1) : window_len;
  assign used    = ({1'b0, frame_phase} + 9'd1) >= {1'b0, dec_eff};
  assign ready   = (st == S_IDLE);
  assign cfg_ready = 1'b1;

  assign acc_clr = '{sq: '0, sum: '0, vmax: 16'sh8000, vmin: 16'sh7fff, cnt: '0};

  // accumulator update
  assign mag    = s_q[SmpBits-1] ? 16'(-s_q) : s_q;
  assign sq     = SqBits'({{SmpBits{1'b0}}, mag} * {{SmpBits{1'b0}}, mag});
  assign sq_sum = {1'b0, rdata.sq} + {1'b0, sq};
  assign ps     = {rdata.sum[SumBits-1], rdata.sum} + (SumBits+1)'(s_q);
  always_comb begin
    acc_new.sq  = sq_sum[SqBits] ? '1 : sq_sum[SqBits-1:0];
    if (ps[SumBits] != ps[SumBits-1])
      acc_new.sum = ps[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
    else
      acc_new.sum = ps[SumBits-1:0];
    acc_new.vmax = (s_q > rdata.vmax) ? s_q : rdata.vmax;
    acc_new.vmin = (s_q < rdata.vmin) ? s_q : rdata.vmin;
    acc_new.cnt  = rdata.cnt + CntBits'(1);
  end
  assign close = acc_new.cnt >= len_eff;

  // a close holds in S_MOD until the output register is free
  assign mod_go = (st == S_MOD) && !(close && out_valid);

  assign job = '{ch: ch_q, sq: acc_new.sq, sum: acc_new.sum, vmax: acc_new.vmax,
                 vmin: acc_new.vmin, len: len_eff};
  assign m_start = mod_go && close;

  always_comb begin
    we    = 1'b0;
    waddr = ch_q;
    wdata = acc_new;
    if (st == S_CLR) begin
      we = 1'b1; waddr = clr_idx; wdata = acc_clr;
    end else if (mod_go) begin
      we = 1'b1;
      if (close) wdata = acc_clr;
    end
  end

  wcs_acc_mem u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ch_q), .rdata(rdata)
  );

  wcs_math u_math (
    .clk(clk), .rst(rst), .start(m_start), .job(job), .busy(m_busy), .done(m_done),
    .r_ch(m_ch), .r_rms(m_rms), .r_mean(m_mean), .r_max(m_max), .r_min(m_min),
    .r_p2p(m_p2p)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= 16'd1000;
      decimation <= 8'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegWindowLen:  window_len <= cfg_data;
        RegDecimation: decimation <= cfg_data[DecBits-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_CLR;
      clr_idx     <= '0;
      frame_phase <= '0;
    end else begin
      unique case (st)
        S_CLR: begin
          clr_idx <= clr_idx + ChBits'(1);
          if (clr_idx == ChBits'(Channels - 1)) st <= S_IDLE;
        end
        S_IDLE: if (valid) begin
          s_q  <= sample;
          ch_q <= channel;
          if (frame_end)
            frame_phase <= used ? '0 : frame_phase + DecBits'(1);
          if (used) st <= S_RD;
        end
        S_RD:  st <= S_MOD;
        S_MOD: if (mod_go) st <= close ? S_WAIT : S_IDLE;
        S_WAIT: if (!m_busy) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (m_done) begin
        out_valid    <= 1'b1;
        out_channel  <= m_ch;
        rms          <= m_rms;
        mean         <= m_mean;
        maximum      <= m_max;
        minimum      <= m_min;
        peak_to_peak <= m_p2p;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

@@ tb/tb_windowed_channel_statistics_unit.sv @@
`timescale 1ns / 1ps

module tb_windowed_channel_statistics_unit;
  import wcs_pkg::*;

  // Channel statistics result as seen on the output ports
  typedef struct packed {
    logic [3:0]         ch;
    logic [15:0]        rms;
    logic signed [15:0] mean;
    logic signed [15:0] vmax;
    logic signed [15:0] vmin;
    logic [15:0]        p2p;
  } stats_t;

  localparam longint CycleLimit = 4000000;
  localparam logic [47:0] SqSat = 48'hFFFF_FFFF_FFFF;
  localparam longint SumHi = (longint'(1) << 39) - 1;
  localparam longint SumLo = -(longint'(1) << 39);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic signed [15:0] sample = '0;
  logic [3:0] channel = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_channel;
  logic [15:0] rms;
  logic signed [15:0] mean;
  logic signed [15:0] maximum;
  logic signed [15:0] minimum;
  logic [15:0] peak_to_peak;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the block's state and registers
  logic [47:0] sq_acc [Channels];
  longint sum_acc [Channels];
  logic signed [15:0] max_acc [Channels];
  logic signed [15:0] min_acc [Channels];
  logic [15:0] cnt_acc [Channels];
  logic [7:0] phase_q;
  logic [15:0] win_len_q;
  logic [7:0] dec_q;

  stats_t window_results_q[$];
  int mismatches = 0;
  int results_seen = 0;
  longint cycles = 0;
  int items_sent = 0;
  bit sink_stall = 1'b1;

  windowed_channel_statistics_unit i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'h1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic clear_shadow_channel(int c);
    sq_acc[c] = '0;
    sum_acc[c] = 0;
    max_acc[c] = -16'sd32768;
    min_acc[c] = 16'sd32767;
    cnt_acc[c] = '0;
  endtask

  // Accumulate one sample and queue a result when its window closes
  task automatic predict_sample(logic signed [15:0] s, logic [3:0] ch, logic fe);
    logic [7:0] dec;
    logic [15:0] len;
    logic used;
    logic [47:0] sq;
    longint ps;
    stats_t r;
    int c;
    dec = (dec_q == 0) ? 8'd1 : dec_q;
    len = (win_len_q == 0) ? 16'd1 : win_len_q;
    used = ({1'b0, phase_q} + 9'd1) >= {1'b0, dec};
    c = ch;
    if (used) begin
      sq = 48'(longint'(s) * longint'(s));
      sq_acc[c] = (sq_acc[c] > SqSat - sq) ? SqSat : sq_acc[c] + sq;
      ps = sum_acc[c] + longint'(s);
      if (ps > SumHi) ps = SumHi;
      if (ps < SumLo) ps = SumLo;
      sum_acc[c] = ps;
      if (s > max_acc[c]) max_acc[c] = s;
      if (s < min_acc[c]) min_acc[c] = s;
      cnt_acc[c] = cnt_acc[c] + 16'd1;
      if (cnt_acc[c] >= len) begin
        r.ch = ch;
        r.rms = 16'(int_root({16'd0, sq_acc[c]} / len));
        r.mean = 16'(sum_acc[c] / longint'(len));
        r.vmax = max_acc[c];
        r.vmin = min_acc[c];
        r.p2p = 16'(int'(max_acc[c]) - int'(min_acc[c]));
        window_results_q.push_back(r);
        clear_shadow_channel(c);
      end
    end
    if (fe) phase_q = used ? 8'd0 : phase_q + 8'd1;
  endtask

  // One sample transfer with a random lead gap; valid stays up when there is none
  task automatic send_sample(logic signed [15:0] s, logic [3:0] ch, logic fe);
    int g;
    g = gap_len();
    if (g != 0) begin
      valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    valid <= 1'b1;
    sample <= s;
    channel <= ch;
    frame_end <= fe;
    @(posedge clk);
    while (!ready) @(posedge clk);
    predict_sample(s, ch, fe);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    while (window_results_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == RegWindowLen) win_len_q = data;
    else dec_q = data[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    stats_t got, exp_r;
    if (!rst && out_valid && out_ready) begin
      got = '{out_channel, rms, mean, maximum, minimum, peak_to_peak};
      results_seen++;
      if (window_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = window_results_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  // Sink stalls
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (sink_stall && g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      out_ready <= 1'b1;
      if (sink_stall) repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  end

  task automatic test_reset_defaults();
    // default window 1000, decimation 4: skip three frames, close one window on channel 3
    int i;
    for (i = 0; i < 3; i++) send_sample(16'sd100, 4'd3, 1'b1);
    sink_stall = 1'b0;
    for (i = 0; i < 1000; i++) begin
      send_sample(i[0] ? 16'sd32767 : -16'sd32768, 4'd3, 1'b0);
    end
    wait_drained();
    sink_stall = 1'b1;
  endtask

  task automatic test_extremes();
    // every frame used, window of one, then two
    write_reg(RegDecimation, 16'd0);
    write_reg(RegWindowLen, 16'd0);
    send_sample(-16'sd32768, 4'd0, 1'b0);
    send_sample(16'sd32767, 4'd15, 1'b1);
    send_sample(16'sd0, 4'd7, 1'b0);
    send_sample(-16'sd1, 4'd8, 1'b1);
    write_reg(RegWindowLen, 16'd2);
    send_sample(-16'sd32768, 4'd1, 1'b0);
    send_sample(16'sd32767, 4'd1, 1'b0);
    send_sample(-16'sd3, 4'd2, 1'b0);
    send_sample(-16'sd4, 4'd2, 1'b1);
    // lowering the window mid-way closes on the next sample
    write_reg(RegWindowLen, 16'd6);
    send_sample(16'sd5, 4'd4, 1'b0);
    send_sample(16'sd9, 4'd4, 1'b0);
    send_sample(16'sd11, 4'd4, 1'b0);
    write_reg(RegWindowLen, 16'd2);
    send_sample(-16'sd7, 4'd4, 1'b1);
    // decimation 255 skips many frames
    write_reg(RegDecimation, 16'd255);
    send_sample(16'sd21, 4'd5, 1'b1);
    send_sample(16'sd22, 4'd5, 1'b1);
    write_reg(RegDecimation, 16'd3);
    send_sample(16'sd1, 4'd5, 1'b1);
    send_sample(16'sd2, 4'd5, 1'b1);
    send_sample(16'sd3, 4'd5, 1'b1);
    send_sample(16'sd4, 4'd5, 1'b0);
    // hold off until all results are in
    wait_drained();
  endtask

  task automatic test_random_frames(int n_items);
    int i, k, flen;
    logic signed [15:0] s;
    i = 0;
    while (i < n_items) begin
      flen = $urandom_range(1, 8);
      for (k = 0; k < flen; k++) begin
        s = ($urandom_range(0, 9) == 0) ?
            ($urandom_range(0, 1) ? 16'sd32767 : -16'sd32768) : 16'($urandom);
        send_sample(s, 4'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                    (k == flen - 1) ? 1'b1 : ($urandom_range(0, 19) == 0));
        i++;
      end
    end
  endtask

  task automatic test_random_settings();
    int p;
    for (p = 0; p < 8; p++) begin
      write_reg(RegWindowLen, 16'($urandom_range(1, 5)));
      write_reg(RegDecimation, 16'($urandom_range(1, 3)));
      test_random_frames(80);
    end
    write_reg(RegWindowLen, 16'hFFFF);
    write_reg(RegDecimation, 16'd1);
    test_random_frames(60);
  endtask

  initial begin
    int c;
    for (c = 0; c < Channels; c++) clear_shadow_channel(c);
    phase_q = '0;
    win_len_q = 16'd1000;
    dec_q = 8'd4;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extremes();
    test_random_settings();
    wait_drained();
    $display("sent %0d samples, checked %0d window results over several settings",
             items_sent, results_seen);
    if (mismatches == 0 && window_results_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, window_results_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ windowed_channel_statistics_unit.f @@
sv/wcs_pkg.sv
sv/wcs_acc_mem.sv
sv/wcs_math.sv
sv/windowed_channel_statistics_unit.sv
tb/tb_windowed_channel_statistics_unit.sv
